FILE: design/sdrs_pkg.sv
// Shared types and constants of the SCAN disk request scheduler.
package sdrs_pkg;

    localparam int CYL_W     = 16;
    localparam int SEEK_W    = 17;
    localparam int ACC_W     = 18;
    localparam int DISK_W    = 17;
    localparam int CFG_IDX_W = 2;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;

    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_DISK_CYLINDERS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_UP       = 2'd2;

    typedef struct packed {
        logic insert;
        logic close;
        logic find_step;
        logic seg1_start;
        logic seg2_start;
        logic serve;
        logic travel;
        logic emit;
        logic done;
    } dp_cmd_t;

    typedef struct packed {
        logic batch_end;
        logic find_hit;
        logic seg1_empty;
        logic seg2_empty;
        logic seg_last;
    } dp_status_t;

endpackage

FILE: design/sdrs_ctrl.sv
// Sequencing controller: load, split search, serve, end travel and result transfer.
module sdrs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output sdrs_pkg::dp_cmd_t    cmd,
    input  sdrs_pkg::dp_status_t st
);
    import sdrs_pkg::*;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_FIND,
        ST_SERVE,
        ST_TRAVEL,
        ST_EMIT
    } state_t;

    state_t state_reg;
    logic   phase_reg;
    logic   seg_last_reg;
    logic   final_reg;
    logic   m_tvalid_reg;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign s_tready = (state_reg == ST_LOAD);

    always_comb begin
        cmd = '0;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_tvalid) begin
                    cmd.insert = 1'b1;
                    cmd.close  = st.batch_end;
                end
            end
            ST_FIND: begin
                cmd.seg1_start = st.find_hit;
                cmd.find_step  = !st.find_hit;
            end
            ST_SERVE: begin
                cmd.serve = 1'b1;
            end
            ST_TRAVEL: begin
                cmd.travel     = 1'b1;
                cmd.seg2_start = 1'b1;
            end
            ST_EMIT: begin
                cmd.emit = out_free;
                cmd.done = final_reg || (phase_reg && seg_last_reg);
            end
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            phase_reg    <= 1'b0;
            seg_last_reg <= 1'b0;
            final_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_tvalid && st.batch_end) begin
                        phase_reg <= 1'b0;
                        final_reg <= 1'b0;
                        state_reg <= ST_FIND;
                    end
                end
                ST_FIND: begin
                    if (st.find_hit) begin
                        state_reg <= st.seg1_empty ? ST_TRAVEL : ST_SERVE;
                    end
                end
                ST_SERVE: begin
                    seg_last_reg <= st.seg_last;
                    if (st.seg_last && !phase_reg && st.seg2_empty) begin
                        state_reg <= ST_TRAVEL;
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_TRAVEL: begin
                    phase_reg <= 1'b1;
                    if (st.seg2_empty) begin
                        final_reg <= 1'b1;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_SERVE;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        if (cmd.done) begin
                            state_reg <= ST_LOAD;
                        end else if (seg_last_reg) begin
                            state_reg <= ST_TRAVEL;
                        end else begin
                            state_reg <= ST_SERVE;
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

endmodule

FILE: design/sdrs_datapath.sv
// Datapath: sorted request row, split index, head and seek accumulator, result register.
module sdrs_datapath #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [sdrs_pkg::CYL_W-1:0]  request_cylinder,
    input  logic                        last_request,
    input  logic [sdrs_pkg::CYL_W-1:0]  top_cyl,
    input  logic [sdrs_pkg::CYL_W-1:0]  start_head,
    input  logic                        sweep_up,
    input  sdrs_pkg::dp_cmd_t           cmd,
    output sdrs_pkg::dp_status_t        st,
    output logic [sdrs_pkg::CYL_W-1:0]  served_cylinder,
    output logic [sdrs_pkg::SEEK_W-1:0] seek_so_far,
    output logic                        batch_done
);
    import sdrs_pkg::*;

    localparam int IDX_W = $clog2(MAX_REQUESTS);
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_REQUESTS - 1);

    logic [CYL_W-1:0]  sorted_reg [MAX_REQUESTS];
    logic [CYL_W-1:0]  sorted_next [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] le;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  n_reg;
    logic [CNT_W-1:0]  pos_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              dir_reg;
    logic              sweep_reg;
    logic [CYL_W-1:0]  head_reg;
    logic [ACC_W-1:0]  seek_reg;
    logic [CYL_W-1:0]  cyl_sat;
    logic [CYL_W-1:0]  head_sat;
    logic [CYL_W-1:0]  rd_cyl;
    logic [CYL_W-1:0]  travel_tgt;
    logic [CYL_W-1:0]  serve_dist;
    logic [CYL_W-1:0]  travel_dist;
    logic [CYL_W-1:0]  out_cyl_reg;
    logic [CYL_W-1:0]  res_cyl_reg;
    logic [SEEK_W-1:0] res_seek_reg;
    logic              res_done_reg;

    assign cyl_sat    = (request_cylinder > top_cyl) ? top_cyl : request_cylinder;
    assign head_sat   = (start_head > top_cyl) ? top_cyl : start_head;
    assign rd_cyl     = sorted_reg[idx_reg[IDX_W-1:0]];
    assign travel_tgt = sweep_reg ? top_cyl : '0;
    assign serve_dist = (rd_cyl > head_reg) ? rd_cyl - head_reg : head_reg - rd_cyl;
    assign travel_dist = (travel_tgt > head_reg) ? travel_tgt - head_reg
                                                 : head_reg - travel_tgt;

    assign served_cylinder = res_cyl_reg;
    assign seek_so_far     = res_seek_reg;
    assign batch_done      = res_done_reg;

    always_comb begin
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            le[i] = (CNT_W'(i) < cnt_reg) && (sorted_reg[i] <= cyl_sat);
        end
        for (int i = 0; i < MAX_REQUESTS; i++) begin
            if (le[i]) begin
                sorted_next[i] = sorted_reg[i];
            end else if (i == 0) begin
                sorted_next[i] = cyl_sat;
            end else if (le[i-1]) begin
                sorted_next[i] = cyl_sat;
            end else begin
                sorted_next[i] = sorted_reg[i-1];
            end
        end
    end

    assign st.batch_end  = last_request || (cnt_reg == CNT_LAST);
    assign st.find_hit   = (idx_reg == n_reg) || (rd_cyl > head_reg);
    assign st.seg1_empty = sweep_reg ? (idx_reg == n_reg) : (idx_reg == '0);
    assign st.seg2_empty = sweep_reg ? (pos_reg == '0) : (pos_reg == n_reg);
    assign st.seg_last   = dir_reg ? (idx_reg + CNT_W'(1) == n_reg) : (idx_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.insert) begin
            cnt_reg <= cmd.close ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            sorted_reg <= sorted_next;
        end
        if (cmd.close) begin
            n_reg     <= cnt_reg + CNT_W'(1);
            idx_reg   <= '0;
            head_reg  <= head_sat;
            seek_reg  <= '0;
            sweep_reg <= sweep_up;
        end
        if (cmd.find_step) begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
        if (cmd.seg1_start) begin
            pos_reg <= idx_reg;
            dir_reg <= sweep_reg;
            idx_reg <= sweep_reg ? idx_reg : idx_reg - CNT_W'(1);
        end
        if (cmd.seg2_start) begin
            dir_reg <= !sweep_reg;
            idx_reg <= sweep_reg ? pos_reg - CNT_W'(1) : pos_reg;
        end
        if (cmd.serve) begin
            out_cyl_reg <= rd_cyl;
            seek_reg    <= seek_reg + ACC_W'(serve_dist);
            head_reg    <= rd_cyl;
            idx_reg     <= dir_reg ? idx_reg + CNT_W'(1) : idx_reg - CNT_W'(1);
        end
        if (cmd.travel) begin
            seek_reg <= seek_reg + ACC_W'(travel_dist);
            head_reg <= travel_tgt;
        end
        if (cmd.emit) begin
            res_cyl_reg  <= out_cyl_reg;
            res_seek_reg <= seek_reg[ACC_W-1] ? SEEK_MAX : seek_reg[SEEK_W-1:0];
            res_done_reg <= cmd.done;
        end
    end

endmodule

FILE: design/scan_disk_request_scheduler_top.sv
// Top level of the SCAN disk request scheduler: configuration registers and unit wiring.
// Requests are taken one per cycle until one arrives with tlast or the store of
// MAX_REQUESTS fills. The batch of n requests is kept sorted as it loads. After the
// last request the split point is searched one entry per cycle, then each served
// request is first stepped through the seek accumulator and then transferred into
// the output register, and each batch adds one travel to the disk end.
// No request is taken while a batch is being served; the next batch may start loading
// while its predecessor's final result still waits in the output register. tlast on
// the output marks the result that carries the batch's total seek, saturated at
// 131071.
module scan_disk_request_scheduler_top #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [sdrs_pkg::S_TDATA_W-1:0]   s_tdata,   // [15:0] request_cylinder
    input  logic                             s_tlast,   // last_request
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [sdrs_pkg::M_TDATA_W-1:0]   m_tdata,   // [15:0] served_cylinder, [32:16] seek_so_far
    output logic                             m_tlast,   // batch_done
    input  logic                             cfg_wr_en,
    input  logic [sdrs_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [sdrs_pkg::DISK_W-1:0]      cfg_wdata
);
    import sdrs_pkg::*;

    logic [DISK_W-1:0] disk_cylinders_reg;
    logic [CYL_W-1:0]  start_head_reg;
    logic              sweep_up_reg;
    logic [CYL_W-1:0]  top_cyl;
    logic [CYL_W-1:0]  served_cylinder;
    logic [SEEK_W-1:0] seek_so_far;
    dp_cmd_t           cmd;
    dp_status_t        st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            disk_cylinders_reg <= DISK_W'(65536);
            start_head_reg     <= '0;
            sweep_up_reg       <= 1'b1;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DISK_CYLINDERS: disk_cylinders_reg <= cfg_wdata;
                CFG_START_HEAD:     start_head_reg     <= cfg_wdata[CYL_W-1:0];
                CFG_SWEEP_UP:       sweep_up_reg       <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (disk_cylinders_reg == '0) begin
            top_cyl = '0;
        end else if (disk_cylinders_reg[DISK_W-1]) begin
            top_cyl = {CYL_W{1'b1}};
        end else begin
            top_cyl = disk_cylinders_reg[CYL_W-1:0] - CYL_W'(1);
        end
    end

    sdrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .st       (st)
    );

    sdrs_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .request_cylinder (s_tdata[CYL_W-1:0]),
        .last_request     (s_tlast),
        .top_cyl          (top_cyl),
        .start_head       (start_head_reg),
        .sweep_up         (sweep_up_reg),
        .cmd              (cmd),
        .st               (st),
        .served_cylinder  (served_cylinder),
        .seek_so_far      (seek_so_far),
        .batch_done       (m_tlast)
    );

    assign m_tdata = {(M_TDATA_W - CYL_W - SEEK_W)'(0), seek_so_far, served_cylinder};

endmodule
